### sv/ttiu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttiu_pkg: thermistor table interpolator package
// Widths, ohms table, status codes and stage payload types.
// ----------------------------------------------------------------------------
package ttiu_pkg;

  localparam int unsigned TableEntries    = 37;
  localparam int unsigned CodeW           = 16;
  localparam int unsigned OhmsW           = 16;
  localparam int unsigned TempW           = 9;
  localparam int unsigned StatusW         = 2;
  localparam int unsigned IdxW            = $clog2(TableEntries);
  // positive ADC code (15 bits) times series resistor (16 bits)
  localparam int unsigned ProdW           = CodeW - 1 + OhmsW;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = OhmsW / DivBitsPerStage;
  // front (2) + divider + lookup (2) + interpolation (2)
  localparam int unsigned NumStages       = DivStages + 6;

  localparam int StepDeg = 5;
  localparam int BaseDeg = 40;
  // quotient of the fractional step is below StepDeg
  localparam int unsigned FracBits = $clog2(StepDeg);
  localparam int unsigned XW       = OhmsW + FracBits;

  localparam logic [OhmsW-1:0]        SeriesReset = OhmsW'(220);
  localparam logic signed [TempW-1:0] ColdDeg     = TempW'(-BaseDeg);
  localparam logic signed [TempW-1:0] HotDeg      =
    TempW'((TableEntries - 1) * StepDeg - BaseDeg);

  // descending resistance, one entry per 5 degC from -40 degC
  localparam logic [OhmsW-1:0] OhmsTable [TableEntries] = '{
    16'd44864, 16'd33676, 16'd25524, 16'd19525, 16'd15067, 16'd11724,
    16'd9195,  16'd7266,  16'd5784,  16'd4636,  16'd3740,  16'd3037,
    16'd2480,  16'd2038,  16'd1683,  16'd1398,  16'd1167,  16'd978,
    16'd825,   16'd698,   16'd594,   16'd507,   16'd435,   16'd374,
    16'd323,   16'd280,   16'd244,   16'd213,   16'd186,   16'd164,
    16'd144,   16'd128,   16'd113,   16'd100,   16'd90,    16'd80,
    16'd72
  };

  typedef enum logic [StatusW-1:0] {
    StInterp  = 2'd0,
    StCold    = 2'd1,
    StHot     = 2'd2,
    StInvalid = 2'd3
  } status_e;

  typedef struct packed {
    logic             invalid;
    logic [OhmsW-1:0] den;
    logic [ProdW-1:0] num;
  } mul_t;

  typedef struct packed {
    logic             invalid;
    logic             sat;
    logic [OhmsW-1:0] den;
    logic [OhmsW-1:0] rem;
    logic [OhmsW-1:0] work;  // dividend bits in, quotient bits out
  } div_t;

  typedef struct packed {
    logic                    invalid;
    logic [OhmsW-1:0]        ohms;
    logic [TableEntries-1:0] ge;
  } cmp_t;

  typedef struct packed {
    logic                    invalid;
    logic                    cold;
    logic                    hot;
    logic [OhmsW-1:0]        ohms;
    logic [OhmsW-1:0]        hi;
    logic [OhmsW-1:0]        lo;
    logic signed [TempW-1:0] base;
  } seg_t;

  typedef struct packed {
    logic                    invalid;
    logic                    cold;
    logic                    hot;
    logic [OhmsW-1:0]        ohms;
    logic [XW-1:0]           x;
    logic [OhmsW-1:0]        span;
    logic signed [TempW-1:0] base;
  } frac_t;

  // temperature at the start of segment idx
  function automatic logic signed [TempW-1:0] seg_base(logic [IdxW-1:0] idx);
    return TempW'(int'(idx) * StepDeg - BaseDeg);
  endfunction

endpackage
`default_nettype wire

### sv/ttiu_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttiu_in_if: sample channel
// Valid/ready channel carrying one pair of ADC codes per transaction.
// ----------------------------------------------------------------------------
interface ttiu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ttiu_pkg::CodeW-1:0]    ref_code;
  logic signed [ttiu_pkg::CodeW-1:0]    meas_code;

  modport source (output valid, ref_code, meas_code, input ready);
  modport sink   (input valid, ref_code, meas_code, output ready);
endinterface
`default_nettype wire

### sv/ttiu_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttiu_out_if: result channel
// Valid/ready channel carrying temperature, resistance and status.
// ----------------------------------------------------------------------------
interface ttiu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ttiu_pkg::TempW-1:0]    temp_celsius;
  logic [ttiu_pkg::OhmsW-1:0]           sensor_ohms;
  logic [ttiu_pkg::StatusW-1:0]         status;

  modport source (output valid, temp_celsius, sensor_ohms, status, input ready);
  modport sink   (input valid, temp_celsius, sensor_ohms, status, output ready);
endinterface
`default_nettype wire

### sv/ttiu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttiu_front: divider front end
// Stage 0: divisor and product. Stage 1: saturation check and divider setup.
// ----------------------------------------------------------------------------
module ttiu_front (
  input  logic                              clk_i,
  input  logic [1:0]                        ld_i,
  input  logic signed [ttiu_pkg::CodeW-1:0] ref_code_i,
  input  logic signed [ttiu_pkg::CodeW-1:0] meas_code_i,
  input  logic [ttiu_pkg::OhmsW-1:0]        series_ohms_i,
  output ttiu_pkg::div_t                    div_o
);
  import ttiu_pkg::*;

  logic signed [CodeW:0] diff;
  logic [CodeW-2:0]      meas_mag;
  mul_t                  mul_d, mul_q;
  div_t                  div_d, div_q;

  always_comb begin
    diff = {ref_code_i[CodeW-1], ref_code_i} - {meas_code_i[CodeW-1], meas_code_i};
    // negative node code gives a negative quotient, which saturates to 0
    meas_mag = meas_code_i[CodeW-1] ? '0 : meas_code_i[CodeW-2:0];
    mul_d.invalid = diff[CodeW] || (diff == '0);
    mul_d.den     = diff[OhmsW-1:0];
    mul_d.num     = ProdW'(meas_mag) * ProdW'(series_ohms_i);
  end

  always_comb begin
    div_d.invalid = mul_q.invalid;
    // quotient overflows 16 bits when the upper product half reaches den
    div_d.sat     = OhmsW'(mul_q.num[ProdW-1:OhmsW]) >= mul_q.den;
    div_d.den     = mul_q.den;
    div_d.rem     = OhmsW'(mul_q.num[ProdW-1:OhmsW]);
    div_d.work    = mul_q.num[OhmsW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      mul_q <= mul_d;
    end
    if (ld_i[1]) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule
`default_nettype wire

### sv/ttiu_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttiu_div_stage: restoring divider stage
// Retires DivBitsPerStage quotient bits per register stage.
// ----------------------------------------------------------------------------
module ttiu_div_stage (
  input  logic           clk_i,
  input  logic           ld_i,
  input  ttiu_pkg::div_t div_i,
  output ttiu_pkg::div_t div_o
);
  import ttiu_pkg::*;

  div_t div_d, div_q;

  always_comb begin
    logic [OhmsW:0] trial;
    logic           qbit;
    div_d = div_i;
    for (int b = 0; b < DivBitsPerStage; b++) begin
      trial = {div_d.rem, div_d.work[OhmsW-1]};
      if (trial >= {1'b0, div_d.den}) begin
        div_d.rem = OhmsW'(trial - {1'b0, div_d.den});
        qbit      = 1'b1;
      end else begin
        div_d.rem = trial[OhmsW-1:0];
        qbit      = 1'b0;
      end
      div_d.work = {div_d.work[OhmsW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule
`default_nettype wire

### sv/ttiu_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttiu_lookup: table segment search
// Stage A: compare resistance against every entry. Stage B: encode segment.
// ----------------------------------------------------------------------------
module ttiu_lookup (
  input  logic           clk_i,
  input  logic [1:0]     ld_i,
  input  ttiu_pkg::div_t div_i,
  output ttiu_pkg::seg_t seg_o
);
  import ttiu_pkg::*;

  cmp_t cmp_d, cmp_q;
  seg_t seg_d, seg_q;

  always_comb begin
    cmp_d.invalid = div_i.invalid;
    if (div_i.invalid) begin
      cmp_d.ohms = '0;
    end else if (div_i.sat) begin
      cmp_d.ohms = '1;
    end else begin
      cmp_d.ohms = div_i.work;
    end
    for (int j = 0; j < TableEntries; j++) begin
      cmp_d.ge[j] = OhmsTable[j] >= cmp_d.ohms;
    end
  end

  // table is descending, so ge is a run of ones from entry 0
  always_comb begin
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] lo_idx;
    logic [IdxW-1:0] hi_idx;
    idx = '0;
    for (int j = TableEntries - 1; j >= 0; j--) begin
      if (!cmp_q.ge[j]) begin
        idx = IdxW'(j);
      end
    end
    lo_idx = (idx == '0) ? IdxW'(1) : idx;
    hi_idx = lo_idx - IdxW'(1);
    seg_d.invalid = cmp_q.invalid;
    seg_d.cold    = !cmp_q.ge[0];
    seg_d.hot     = &cmp_q.ge;
    seg_d.ohms    = cmp_q.ohms;
    seg_d.hi      = OhmsTable[hi_idx];
    seg_d.lo      = OhmsTable[lo_idx];
    seg_d.base    = seg_base(hi_idx);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      cmp_q <= cmp_d;
    end
    if (ld_i[1]) begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule
`default_nettype wire

### sv/ttiu_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttiu_interp: segment interpolation
// Stage A: offset and span. Stage B: short quotient, rounding, result select.
// ----------------------------------------------------------------------------
module ttiu_interp (
  input  logic                               clk_i,
  input  logic [1:0]                         ld_i,
  input  ttiu_pkg::seg_t                     seg_i,
  output logic signed [ttiu_pkg::TempW-1:0]  temp_o,
  output logic [ttiu_pkg::OhmsW-1:0]         ohms_o,
  output ttiu_pkg::status_e                  status_o
);
  import ttiu_pkg::*;

  frac_t                   frac_d, frac_q;
  logic signed [TempW-1:0] temp_d, temp_q;
  logic [OhmsW-1:0]        ohms_q;
  status_e                 status_d, status_q;

  always_comb begin
    logic [OhmsW-1:0] offs;
    offs = seg_i.hi - seg_i.ohms;
    frac_d.invalid = seg_i.invalid;
    frac_d.cold    = seg_i.cold;
    frac_d.hot     = seg_i.hot;
    frac_d.ohms    = seg_i.ohms;
    frac_d.x       = XW'(offs) * XW'(StepDeg);
    frac_d.span    = seg_i.hi - seg_i.lo;
    frac_d.base    = seg_i.base;
  end

  // x / span lies in 0..StepDeg-1; negative sums truncate up towards zero
  always_comb begin
    logic [XW-1:0]       rem;
    logic [XW-1:0]       sub;
    logic [FracBits-1:0] q;
    logic                round_up;
    logic [TempW-1:0]    sum;
    rem = frac_q.x;
    q   = '0;
    for (int b = FracBits - 1; b >= 0; b--) begin
      sub = XW'(frac_q.span) << b;
      if (rem >= sub) begin
        rem  = rem - sub;
        q[b] = 1'b1;
      end
    end
    round_up = frac_q.base[TempW-1] && (rem != '0);
    sum = TempW'(frac_q.base) + TempW'(q) + TempW'(round_up);
    if (frac_q.invalid) begin
      temp_d   = '0;
      status_d = StInvalid;
    end else if (frac_q.cold) begin
      temp_d   = ColdDeg;
      status_d = StCold;
    end else if (frac_q.hot) begin
      temp_d   = HotDeg;
      status_d = StHot;
    end else begin
      temp_d   = $signed(sum);
      status_d = StInterp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      frac_q <= frac_d;
    end
    if (ld_i[1]) begin
      temp_q   <= temp_d;
      ohms_q   <= frac_q.ohms;
      status_q <= status_d;
    end
  end

  assign temp_o   = temp_q;
  assign ohms_o   = ohms_q;
  assign status_o = status_q;

endmodule
`default_nettype wire

### sv/thermistor_table_interpolator_unit.sv
`default_nettype none
// Throughput: one transaction per cycle unless the output stalls, set by the
//   14-stage pipeline in which the 16-bit restoring divider retires two
//   quotient bits per stage.
// Reset: rst_ni clears every stage valid bit and loads series_ohms with 220;
//   the block accepts samples in the first cycle after reset.
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_unit: NTC thermistor temperature pipeline
// Converts divider ADC codes to resistance and interpolates a 5 degC table.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ttiu_pkg::OhmsW-1:0]  cfg_wdata_i,
  ttiu_in_if.sink                     sample_i,
  ttiu_out_if.source                  result_o
);
  import ttiu_pkg::*;

  // Stage map
  //   0            : ref - meas and meas * series_ohms
  //   1            : overflow check, divider setup
  //   2 .. 9       : divider, two quotient bits each
  //   10           : resistance clamp, compare against all table entries
  //   11           : segment encode, table read of both segment ends
  //   12           : offset within segment times 5, segment span
  //   13           : fractional quotient, rounding, output register

  logic [OhmsW-1:0]        series_q;
  logic [NumStages-1:0]    vld_q;
  logic [NumStages-1:0]    vld_d;
  logic [NumStages:0]      ld;
  div_t                    div_chain [DivStages+1];
  seg_t                    seg;
  logic signed [TempW-1:0] temp;
  logic [OhmsW-1:0]        ohms;
  status_e                 status;

  // Series resistor; user writes only while the pipeline is empty, unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= SeriesReset;
    end else if (cfg_we_i) begin
      series_q <= cfg_wdata_i;
    end
  end

  // A stage loads when it is empty or when the stage after it loads, so
  // bubbles collapse and a stall at the output holds every occupied stage.
  assign ld[NumStages] = result_o.ready;
  for (genvar k = 0; k < NumStages; k++) begin : g_ld
    assign ld[k] = !vld_q[k] || ld[k+1];
  end

  assign vld_d = {vld_q[NumStages-2:0], sample_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~ld[NumStages-1:0]) | (vld_d & ld[NumStages-1:0]);
    end
  end

  assign sample_i.ready = ld[0];

  ttiu_front u_front (
    .clk_i         (clk_i),
    .ld_i          (ld[1:0]),
    .ref_code_i    (sample_i.ref_code),
    .meas_code_i   (sample_i.meas_code),
    .series_ohms_i (series_q),
    .div_o         (div_chain[0])
  );

  for (genvar d = 0; d < DivStages; d++) begin : g_div
    ttiu_div_stage u_div_stage (
      .clk_i (clk_i),
      .ld_i  (ld[2+d]),
      .div_i (div_chain[d]),
      .div_o (div_chain[d+1])
    );
  end

  ttiu_lookup u_lookup (
    .clk_i (clk_i),
    .ld_i  (ld[DivStages+3:DivStages+2]),
    .div_i (div_chain[DivStages]),
    .seg_o (seg)
  );

  ttiu_interp u_interp (
    .clk_i    (clk_i),
    .ld_i     (ld[DivStages+5:DivStages+4]),
    .seg_i    (seg),
    .temp_o   (temp),
    .ohms_o   (ohms),
    .status_o (status)
  );

  // Last stage is the output register; a transaction completes on ready.
  assign result_o.valid        = vld_q[NumStages-1];
  assign result_o.temp_celsius = temp;
  assign result_o.sensor_ohms  = ohms;
  assign result_o.status       = status;

endmodule
`default_nettype wire

### bench/thermistor_table_interpolator_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_unit_tb: self-checking bench
// Drives ADC code pairs through the valid/ready sample channel and checks each
// result against a behavioural predictor of resistance, table search and
// interpolation. It covers directed edge cases, series resistor extremes,
// random readings with bursty traffic and a long output hold-off.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttiu_pkg::*;

  // Worst case is far below this: ~1250 transactions with sender gaps and
  // receiver stalls, plus one long hold-off.
  localparam int unsigned LimitCycles = 400000;
  // Length of the deliberate output hold-off, in receiver cycles.
  localparam int unsigned HoldCycles  = 150;
  // Settling time after the last result; pipeline depth plus margin.
  localparam int unsigned TailCycles  = 40;

  // One expected result transaction.
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [OhmsW-1:0]        ohms;
    status_e                 status;
  } reading_t;

  logic              clk = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [OhmsW-1:0]  cfg_wdata;

  ttiu_in_if  sample_if ();
  ttiu_out_if result_if ();

  // Mirror of the series resistor register, as the predictor sees it.
  logic [OhmsW-1:0]  series_setting;
  reading_t          expected_readings [$];
  int unsigned       error_count;
  int unsigned       cycle_count;
  // Raised by the hold-off test; the receiver clears it once it has held off.
  bit                hold_request;

  always #1 clk = ~clk;

  thermistor_table_interpolator_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_if),
    .result_o    (result_if)
  );

  // --------------------------------------------------------------------------
  // Predictor: resistance from the divider, then search of the descending
  // table and exact linear interpolation truncated toward zero.
  // --------------------------------------------------------------------------
  function automatic reading_t predict_reading(logic signed [CodeW-1:0] ref_c,
                                               logic signed [CodeW-1:0] meas_c,
                                               logic [OhmsW-1:0]        series);
    reading_t rd;
    longint   num, den, ser, ohms, hi, lo, span, base, deg;
    int       idx;
    rd.temp   = '0;
    rd.ohms   = '0;
    rd.status = StInvalid;
    // invalid divider: reference not above the node
    if (ref_c <= meas_c) return rd;
    ser  = series;
    num  = meas_c;
    num  = num * ser;
    den  = ref_c;
    den  = den - longint'(meas_c);
    ohms = num / den;
    // negative node code gives a negative quotient; saturate both ways
    if (ohms < 0) ohms = 0;
    if (ohms > 65535) ohms = 65535;
    idx = 0;
    while (idx < int'(TableEntries) && ohms <= longint'(OhmsTable[idx])) idx++;
    if (idx == int'(TableEntries)) begin
      // at or below the last entry
      deg       = (int'(TableEntries) - 1) * StepDeg - BaseDeg;
      rd.status = StHot;
    end else if (idx == 0) begin
      // above the first entry; equality with it falls through to interpolation
      deg       = -BaseDeg;
      rd.status = StCold;
    end else begin
      hi   = OhmsTable[idx-1];
      lo   = OhmsTable[idx];
      span = hi - lo;
      base = (idx - 1) * StepDeg - BaseDeg;
      if (span <= 0) deg = base;
      else deg = (base * span + StepDeg * (hi - ohms)) / span;
      rd.status = StInterp;
    end
    rd.temp = deg[TempW-1:0];
    rd.ohms = ohms[OhmsW-1:0];
    return rd;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge; acceptance is judged on
  // the rising edge. Valid stays high between back-to-back transactions.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic signed [CodeW-1:0] ref_c,
                             input logic signed [CodeW-1:0] meas_c);
    @(negedge clk);
    sample_if.valid     <= 1'b1;
    sample_if.ref_code  <= ref_c;
    sample_if.meas_code <= meas_c;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    expected_readings.push_back(predict_reading(ref_c, meas_c, series_setting));
  endtask

  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      sample_if.valid <= 1'b0;
    end
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic wait_idle();
    @(negedge clk);
    sample_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_series(input logic [OhmsW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    series_setting = value;
  endtask

  // Build a pair of codes whose divider lands near a chosen resistance.
  // Most land inside the table, some on an entry, some in the cold region,
  // and the rest are raw codes (invalid dividers, negative nodes, anything).
  task automatic make_pair(output logic signed [CodeW-1:0] ref_c,
                           output logic signed [CodeW-1:0] meas_c);
    int unsigned kind, seg;
    longint      target, m, d;
    kind = $urandom_range(0, 99);
    if (kind >= 80) begin
      ref_c  = CodeW'($urandom());
      meas_c = CodeW'($urandom());
    end else begin
      if (kind < 60) begin
        seg    = $urandom_range(1, TableEntries - 1);
        target = $urandom_range(OhmsTable[seg], OhmsTable[seg-1]);
      end else if (kind < 75) begin
        seg    = $urandom_range(0, TableEntries - 1);
        target = longint'(OhmsTable[seg]) + $urandom_range(0, 2) - 1;
      end else begin
        target = $urandom_range(OhmsTable[0], 65535);
      end
      m = $urandom_range(1, 32767);
      d = (m * series_setting) / target;
      if (d < 1) d = 1;
      while (m + d > 32767 && m > 1) begin
        m = m / 2;
        d = (m * series_setting) / target;
        if (d < 1) d = 1;
      end
      meas_c = m[CodeW-1:0];
      ref_c  = CodeW'(m + d);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Edge cases at the reset value of the series resistor (220 ohms).
  task automatic test_directed_cases();
    send_sample(16'sd32767, 16'sd32767);    // equal codes: invalid
    send_sample(-16'sd32768, 16'sd32767);   // reference far below node
    send_sample(16'sd32767, -16'sd32768);   // negative node, saturates to 0
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd11271, 16'sd11216);    // exactly the first entry
    send_sample(16'sd11272, 16'sd11217);    // just above it: cold clamp
    send_sample(16'sd32767, 16'sd32766);    // saturates to 65535
    send_sample(16'sd73, 16'sd18);          // exactly the last entry: hot
    send_sample(16'sd293, 16'sd73);         // one above the last entry
    send_sample(16'sd2011, 16'sd2000);      // negative interpolation, rounds toward zero
    send_sample(16'sd3960, 16'sd3740);      // exactly an interior entry
    send_sample(16'sd32767, 16'sd0);        // zero ohms
    send_sample(-16'sd32767, -16'sd32768);
    send_sample(-16'sd1, -16'sd32768);
    wait_idle();
  endtask

  // Largest, zero and smallest nonzero series resistor.
  task automatic test_series_extremes();
    write_series(16'hFFFF);
    send_sample(16'sd32767, 16'sd16384);    // just past saturation
    send_sample(16'sd32767, 16'sd1);
    wait_idle();
    write_series(16'h0000);                 // zero resistor: always hot
    send_sample(16'sd2000, 16'sd1000);
    wait_idle();
    write_series(16'h0001);
    send_sample(16'sd32767, 16'sd32766);
    send_sample(16'sd100, 16'sd50);
    wait_idle();
  endtask

  // Random readings; with gaps the sender works in bursts.
  task automatic test_random_readings(input logic [OhmsW-1:0] series,
                                      input int unsigned     count,
                                      input bit              with_gaps);
    logic signed [CodeW-1:0] ref_c, meas_c;
    int unsigned             burst_left;
    write_series(series);
    burst_left = 0;
    repeat (count) begin
      if (with_gaps && burst_left == 0) begin
        idle_sender($urandom_range(1, 6));
        burst_left = $urandom_range(1, 30);
      end
      make_pair(ref_c, meas_c);
      send_sample(ref_c, meas_c);
      if (burst_left != 0) burst_left--;
    end
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering; the pipeline fills
  // and the sample channel must stall without losing or reordering anything.
  task automatic test_output_backpressure();
    logic signed [CodeW-1:0] ref_c, meas_c;
    write_series(16'd4700);
    hold_request = 1'b1;
    repeat (80) begin
      make_pair(ref_c, meas_c);
      send_sample(ref_c, meas_c);
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: changes its stall pattern every so often, and honours a
  // hold-off request by keeping ready low for the HoldCycles hold-off.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned mode, mode_left, held;
    result_if.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_if.ready <= 1'b0;
        for (held = 1; held < HoldCycles; held++) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: begin
            result_if.ready <= 1'b1;
          end
          1: begin
            result_if.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            result_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            result_if.ready <= (mode_left % 3 != 0);
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: temp_celsius %0d, sensor_ohms %0d, status %0d",
               result_if.temp_celsius, result_if.sensor_ohms, result_if.status);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (result_if.temp_celsius !== want.temp) begin
          $error("temp_celsius: expected %0d, got %0d", want.temp,
                 result_if.temp_celsius);
          error_count++;
        end
        if (result_if.sensor_ohms !== want.ohms) begin
          $error("sensor_ohms: expected %0d, got %0d", want.ohms,
                 result_if.sensor_ohms);
          error_count++;
        end
        if (result_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_if.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LimitCycles) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    sample_if.valid     = 1'b0;
    sample_if.ref_code  = '0;
    sample_if.meas_code = '0;
    series_setting      = SeriesReset;
    error_count         = 0;
    hold_request        = 1'b0;
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_series_extremes();
    test_random_readings(16'd220, 250, 1'b1);
    test_random_readings(16'($urandom_range(1, 2000)), 250, 1'b1);
    test_random_readings(16'($urandom_range(2000, 65535)), 250, 1'b0);
    test_output_backpressure();
    test_random_readings(16'hFFFF, 200, 1'b1);
    test_random_readings(16'd1, 200, 1'b1);

    // let anything stray drain out before the verdict
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
